[hw/rtl/sfd_pkg.sv]
// package for the status frame deframer
// frame layout constants, error codes and the result record; no dependencies
package sfd_pkg;

	localparam int POS_W = 5;
	localparam int PAYLOAD_LEN = 21;
	localparam int PIDX_W = $clog2(PAYLOAD_LEN);
	localparam int TDATA_OUT_W = 176;

	localparam logic [POS_W-1:0] POS_SYNC0    = 5'd0;
	localparam logic [POS_W-1:0] POS_SYNC1    = 5'd1;
	localparam logic [POS_W-1:0] POS_TYPE     = 5'd2;
	localparam logic [POS_W-1:0] POS_LENGTH   = 5'd3;
	localparam logic [POS_W-1:0] POS_PAYLOAD  = 5'd4;
	localparam logic [POS_W-1:0] POS_SUM      = 5'd25;
	localparam logic [POS_W-1:0] POS_TRAIL0   = 5'd26;
	localparam logic [POS_W-1:0] POS_TRAIL1   = 5'd27;
	localparam logic [POS_W-1:0] FRAME_LEN    = 5'd28;
	localparam logic [POS_W-1:0] MIN_LEN      = 5'd7;

	localparam logic [7:0] SYNC0_BYTE  = 8'hAA;
	localparam logic [7:0] SYNC1_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_BYTE   = 8'h01;
	localparam logic [7:0] LENGTH_BYTE = 8'd21;
	localparam logic [7:0] TRAIL0_BYTE = 8'h0D;
	localparam logic [7:0] TRAIL1_BYTE = 8'h0A;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_SYNC     = 3'd2,
		ERR_TYPE     = 3'd3,
		ERR_LENGTH   = 3'd4,
		ERR_SUM      = 3'd5,
		ERR_TRAILER  = 3'd6
	} err_code_t;

	typedef struct packed {
		logic               frame_ok;
		err_code_t          error_code;
		logic [31:0]        timestamp;
		logic [7:0]         vehicle_id;
		logic [31:0]        easting_cm;
		logic [31:0]        northing_cm;
		logic signed [15:0] heading_decideg;
		logic [15:0]        speed_decimps;
		logic [7:0]         battery_percent;
		logic signed [15:0] tilt_decideg;
		logic [7:0]         vehicle_mode;
	} result_t;

endpackage

[hw/rtl/sfd_frame_track.sv]
// per-byte frame tracking: position, running xor, first fault, payload store
// builds the result record on the last byte; uses sfd_pkg
module sfd_frame_track (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      rx_byte,
	input  logic            end_of_buffer,
	output logic            res_valid,
	output sfd_pkg::result_t res
);
	import sfd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	err_code_t        fault_q;
	logic [7:0]       store_q [PAYLOAD_LEN];

	logic [POS_W-1:0] pos_next;
	logic [7:0]       xor_next;
	err_code_t        fault_next;
	err_code_t        hit;
	err_code_t        code;
	logic             in_frame;
	logic             in_payload;
	logic [POS_W-1:0] pidx_full;

	assign in_frame   = pos_q < FRAME_LEN;
	assign in_payload = (pos_q >= POS_PAYLOAD) && (pos_q < POS_SUM);
	assign pidx_full  = pos_q - POS_PAYLOAD;
	assign pos_next   = in_frame ? pos_q + 5'd1 : pos_q;
	assign xor_next   = (in_frame && pos_q >= POS_TYPE && pos_q < POS_SUM) ?
		(xor_q ^ rx_byte) : xor_q;

	always_comb begin
		hit = ERR_OK;
		if (in_frame) begin
			unique case (pos_q)
				POS_SYNC0:  if (rx_byte != SYNC0_BYTE) hit = ERR_SYNC;
				POS_SYNC1:  if (rx_byte != SYNC1_BYTE) hit = ERR_SYNC;
				POS_TYPE:   if (rx_byte != TYPE_BYTE) hit = ERR_TYPE;
				POS_LENGTH: if (rx_byte != LENGTH_BYTE) hit = ERR_LENGTH;
				POS_SUM:    if (rx_byte != xor_q) hit = ERR_SUM;
				POS_TRAIL0: if (rx_byte != TRAIL0_BYTE) hit = ERR_TRAILER;
				POS_TRAIL1: if (rx_byte != TRAIL1_BYTE) hit = ERR_TRAILER;
				default:    hit = ERR_OK;
			endcase
		end
		fault_next = (fault_q == ERR_OK) ? hit : fault_q;
	end

	always_comb begin
		priority if (pos_next < MIN_LEN) begin
			code = ERR_SHORT;
		end else if (fault_next == ERR_SYNC || fault_next == ERR_TYPE ||
			fault_next == ERR_LENGTH) begin
			code = fault_next;
		end else if (pos_next < FRAME_LEN) begin
			code = ERR_SHORT;
		end else begin
			code = fault_next;
		end
	end

	always_comb begin
		res = '0;
		res.error_code = code;
		if (code == ERR_OK) begin
			res.frame_ok        = 1'b1;
			res.timestamp       = {store_q[3], store_q[2], store_q[1], store_q[0]};
			res.vehicle_id      = store_q[4];
			res.easting_cm      = {store_q[8], store_q[7], store_q[6], store_q[5]};
			res.northing_cm     = {store_q[12], store_q[11], store_q[10], store_q[9]};
			res.heading_decideg = {store_q[14], store_q[13]};
			res.speed_decimps   = {store_q[16], store_q[15]};
			res.battery_percent = store_q[17];
			res.tilt_decideg    = {store_q[19], store_q[18]};
			res.vehicle_mode    = store_q[20];
		end
	end

	assign res_valid = take && end_of_buffer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			xor_q   <= '0;
			fault_q <= ERR_OK;
		end else if (take) begin
			if (end_of_buffer) begin
				pos_q   <= '0;
				xor_q   <= '0;
				fault_q <= ERR_OK;
			end else begin
				pos_q   <= pos_next;
				xor_q   <= xor_next;
				fault_q <= fault_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_payload) begin
			store_q[pidx_full[PIDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

[hw/rtl/sfd_out_reg.sv]
// result register between the byte side and the result stream
// holds one result until the receiver takes it; uses sfd_pkg
module sfd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfd_pkg::result_t load_res,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             can_load,
	output sfd_pkg::result_t out_res
);
	import sfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

[hw/rtl/status_frame_deframer.sv]
// top level of the status frame deframer
// instantiates sfd_frame_track and sfd_out_reg; uses sfd_pkg
//
// usage:
//   byte stream in on s_tvalid/s_tready/s_tdata, s_tlast on the last byte
//   of a buffer. one byte is taken per cycle when s_tready is high.
//   frame layout: AA 55, type 01, length 21, 21 payload bytes, xor
//   checksum of type..payload, trailer 0D 0A; bytes past the 28th ignored.
//   one result item per buffer on m_tvalid/m_tready/m_tdata, shown the
//   cycle after the last byte is taken; throughput one byte per cycle when
//   s_tready is high, as each byte needs only a compare, an xor and a store.
//   on error frame_ok is 0 and all status fields are zero.
//   reset clears position, checksum and fault state and drops a pending
//   result. when the receiver stalls the result is held and s_tready
//   stays high only while the result register is free or being emptied.
module status_frame_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // rx_byte[7:0]
	input  logic                             s_tlast,  // end_of_buffer
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// frame_ok[0], error_code[3:1], timestamp[35:4], vehicle_id[43:36],
	// easting_cm[75:44], northing_cm[107:76], heading_decideg[123:108],
	// speed_decimps[139:124], battery_percent[147:140],
	// tilt_decideg[163:148], vehicle_mode[171:164], zero pad[175:172]
	output logic [sfd_pkg::TDATA_OUT_W-1:0] m_tdata
);
	import sfd_pkg::*;

	logic    take;
	logic    res_valid;
	logic    can_load;
	result_t res;
	result_t out_res;

	assign s_tready = can_load;
	assign take     = s_tvalid && s_tready;

	sfd_frame_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.rx_byte       (s_tdata),
		.end_of_buffer (s_tlast),
		.res_valid     (res_valid),
		.res           (res)
	);

	sfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_res  (res),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.can_load  (can_load),
		.out_res   (out_res)
	);

	assign m_tdata = {
		4'd0,
		out_res.vehicle_mode,
		out_res.tilt_decideg,
		out_res.battery_percent,
		out_res.speed_decimps,
		out_res.heading_decideg,
		out_res.northing_cm,
		out_res.easting_cm,
		out_res.vehicle_id,
		out_res.timestamp,
		out_res.error_code,
		out_res.frame_ok
	};

endmodule

[hw/rtl/sfd_checker.sv]
// port-level checks for status_frame_deframer
// bound to the top level; no package dependency
module sfd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("no result after last byte");

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'd0)))
		else $error("frame_ok disagrees with error code");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[175:4] == '0)
		else $error("status fields not zero on error");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[175:172] == 4'd0 && m_tdata[3:1] != 3'd7)
		else $error("bad pad or error code");

endmodule

bind status_frame_deframer sfd_checker u_sfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[sim/status_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for status_frame_deframer: drives byte buffers with
// random gaps and result stalls, predicts each frame verdict, uses sfd_pkg
module status_frame_deframer_tb;
	import sfd_pkg::*;

	typedef struct packed {
		logic               ok;
		err_code_t          code;
		logic [31:0]        timestamp;
		logic [7:0]         vehicle_id;
		logic [31:0]        easting_cm;
		logic [31:0]        northing_cm;
		logic signed [15:0] heading_decideg;
		logic [15:0]        speed_decimps;
		logic [7:0]         battery_percent;
		logic signed [15:0] tilt_decideg;
		logic [7:0]         vehicle_mode;
	} verdict_t;

	class deframe_checker;
		logic [POS_W-1:0] pos;
		logic [7:0]       xsum;
		err_code_t        fault;
		logic [7:0]       payload [PAYLOAD_LEN];
		verdict_t         verdict_q [$];
		int               errors;

		function new();
			pos = '0;
			xsum = '0;
			fault = ERR_OK;
			errors = 0;
		endfunction

		task report(string what, logic [31:0] exp_val, logic [31:0] got_val);
			$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_val,
				got_val);
			errors++;
		endtask

		function void note_fault(err_code_t c);
			if (fault == ERR_OK)
				fault = c;
		endfunction

		function void absorb_byte(logic [7:0] b, logic last);
			verdict_t  v;
			err_code_t code;
			if (pos < FRAME_LEN) begin
				if (pos == POS_SYNC0 && b != SYNC0_BYTE) note_fault(ERR_SYNC);
				if (pos == POS_SYNC1 && b != SYNC1_BYTE) note_fault(ERR_SYNC);
				if (pos == POS_TYPE && b != TYPE_BYTE) note_fault(ERR_TYPE);
				if (pos == POS_LENGTH && b != LENGTH_BYTE) note_fault(ERR_LENGTH);
				if (pos >= POS_TYPE && pos < POS_SUM)
					xsum ^= b;
				if (pos >= POS_PAYLOAD && pos < POS_SUM)
					payload[pos - POS_PAYLOAD] = b;
				if (pos == POS_SUM && b != xsum) note_fault(ERR_SUM);
				if (pos == POS_TRAIL0 && b != TRAIL0_BYTE) note_fault(ERR_TRAILER);
				if (pos == POS_TRAIL1 && b != TRAIL1_BYTE) note_fault(ERR_TRAILER);
				pos = pos + 5'd1;
			end
			if (!last)
				return;
			// header faults outrank a short buffer once the minimum length is reached
			if (pos < MIN_LEN)
				code = ERR_SHORT;
			else if (fault == ERR_SYNC || fault == ERR_TYPE || fault == ERR_LENGTH)
				code = fault;
			else if (pos < FRAME_LEN)
				code = ERR_SHORT;
			else
				code = fault;
			v = '0;
			v.code = code;
			if (code == ERR_OK) begin
				v.ok = 1'b1;
				v.timestamp = {payload[3], payload[2], payload[1], payload[0]};
				v.vehicle_id = payload[4];
				v.easting_cm = {payload[8], payload[7], payload[6], payload[5]};
				v.northing_cm = {payload[12], payload[11], payload[10], payload[9]};
				v.heading_decideg = {payload[14], payload[13]};
				v.speed_decimps = {payload[16], payload[15]};
				v.battery_percent = payload[17];
				v.tilt_decideg = {payload[19], payload[18]};
				v.vehicle_mode = payload[20];
			end
			verdict_q.push_back(v);
			pos = '0;
			xsum = '0;
			fault = ERR_OK;
		endfunction

		task field(string name, logic [31:0] exp_val, logic [31:0] got_val);
			if (exp_val !== got_val)
				report(name, exp_val, got_val);
		endtask

		task check_verdict(logic [175:0] d);
			verdict_t v;
			if (verdict_q.size() == 0) begin
				report("result with nothing expected", 32'd0, {29'd0, d[3:1]});
				return;
			end
			v = verdict_q.pop_front();
			field("frame_ok", {31'd0, v.ok}, {31'd0, d[0]});
			field("error_code", {29'd0, v.code}, {29'd0, d[3:1]});
			field("timestamp", v.timestamp, d[35:4]);
			field("vehicle_id", {24'd0, v.vehicle_id}, {24'd0, d[43:36]});
			field("easting_cm", v.easting_cm, d[75:44]);
			field("northing_cm", v.northing_cm, d[107:76]);
			field("heading_decideg", {16'd0, v.heading_decideg}, {16'd0, d[123:108]});
			field("speed_decimps", {16'd0, v.speed_decimps}, {16'd0, d[139:124]});
			field("battery_percent", {24'd0, v.battery_percent}, {24'd0, d[147:140]});
			field("tilt_decideg", {16'd0, v.tilt_decideg}, {16'd0, d[163:148]});
			field("vehicle_mode", {24'd0, v.vehicle_mode}, {24'd0, d[171:164]});
		endtask
	endclass

	localparam int STALL_LIMIT = 2000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;  // rx_byte[7:0]
	logic         s_tlast;  // end_of_buffer
	logic         m_tvalid;
	logic         m_tready;
	logic [175:0] m_tdata;  // frame_ok[0], error_code[3:1], status fields above

	deframe_checker sb = new();
	logic [7:0]     buf_q [$];
	int             bytes_sent = 0;
	bit             idle_on = 1'b1;
	int             quiet_cycles = 0;

	status_frame_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task send_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.absorb_byte(b, last);
		bytes_sent++;
	endtask

	task send_buf();
		for (int i = 0; i < buf_q.size(); i++)
			send_byte(buf_q[i], i == buf_q.size() - 1);
	endtask

	// mode 0 random payload, 1 all zero, 2 all ones, 3 signed field extremes
	task build_frame(input int mode);
		logic [7:0] p;
		logic [7:0] sum;
		buf_q.delete();
		buf_q.push_back(SYNC0_BYTE);
		buf_q.push_back(SYNC1_BYTE);
		buf_q.push_back(TYPE_BYTE);
		buf_q.push_back(LENGTH_BYTE);
		sum = TYPE_BYTE ^ LENGTH_BYTE;
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			case (mode)
				1: p = 8'h00;
				2: p = 8'hFF;
				3: p = (i == 14) ? 8'h80 : (i == 13) ? 8'h00 :
					(i == 19) ? 8'h7F : (i == 18) ? 8'hFF : 8'($urandom);
				default: p = 8'($urandom);
			endcase
			sum ^= p;
			buf_q.push_back(p);
		end
		buf_q.push_back(sum);
		buf_q.push_back(TRAIL0_BYTE);
		buf_q.push_back(TRAIL1_BYTE);
	endtask

	task truncate(input int n);
		while (buf_q.size() > n)
			void'(buf_q.pop_back());
	endtask

	task extend(input int n);
		repeat (n) buf_q.push_back(8'($urandom));
	endtask

	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			sb.check_verdict(m_tdata);

	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status_frame_deframer regression: fail");
		$finish;
	end

	initial begin
		int kind;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: payload extremes
		build_frame(1); send_buf();
		build_frame(2); send_buf();
		build_frame(3); send_buf();
		// each positional fault
		build_frame(0); buf_q[0] ^= 8'h01; send_buf();
		build_frame(0); buf_q[1] = 8'h00; send_buf();
		build_frame(0); buf_q[2] = 8'h02; send_buf();
		build_frame(0); buf_q[3] = 8'd20; send_buf();
		build_frame(0); buf_q[25] ^= 8'h80; send_buf();
		build_frame(0); buf_q[26] = TRAIL1_BYTE; send_buf();
		build_frame(0); buf_q[27] = TRAIL0_BYTE; send_buf();
		// earliest fault wins, checksum outranks trailer
		build_frame(0); buf_q[2] = 8'hFF; buf_q[3] = 8'h00; send_buf();
		build_frame(0); buf_q[25] ^= 8'h01; buf_q[27] = 8'h00; send_buf();
		// short buffers and their ranking against header faults
		build_frame(0); truncate(1); send_buf();
		buf_q.delete(); buf_q.push_back(8'h00); send_buf();
		build_frame(0); truncate(6); send_buf();
		build_frame(0); truncate(7); send_buf();
		build_frame(0); buf_q[1] = 8'hAA; truncate(7); send_buf();
		build_frame(0); truncate(27); send_buf();
		build_frame(0); buf_q[25] ^= 8'h10; truncate(27); send_buf();
		// long buffers: tail is ignored
		build_frame(0); extend(7); send_buf();
		build_frame(0); buf_q[26] = 8'h00; extend(3); send_buf();
		build_frame(2); extend(1); send_buf();

		// random: mostly well-formed frames, some damaged, some noise
		while (bytes_sent < 2000) begin
			idle_on = ($urandom_range(0, 4) != 0) && (bytes_sent < 1700);
			kind = $urandom_range(0, 9);
			build_frame(kind == 0 ? 3 : 0);
			if (kind <= 6) begin
				if ($urandom_range(0, 3) == 0)
					extend($urandom_range(1, 8));
			end else if (kind <= 8) begin
				if ($urandom_range(0, 1) == 0)
					buf_q[$urandom_range(0, 27)] ^= 8'($urandom_range(1, 255));
				else
					truncate($urandom_range(1, 27));
			end else begin
				buf_q.delete();
				extend($urandom_range(1, 35));
			end
			send_buf();
		end
		s_tvalid <= 1'b0;

		while (sb.verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.verdict_q.size() != 0)
			sb.report("expected results never came", sb.verdict_q.size(), 32'd0);
		if (sb.errors == 0)
			$display("status_frame_deframer regression: pass");
		else
			$display("status_frame_deframer regression: fail");
		$finish;
	end

endmodule
